/* hdl/alu8f_pkg.sv */
`timescale 1ns / 1ps

package alu8f_pkg;

    // Operation classes resolved by the decode stage.
    typedef logic [4:0] t_cls;

    localparam t_cls CLS_ADD   = 5'd0;
    localparam t_cls CLS_SUB   = 5'd1;
    localparam t_cls CLS_CMP   = 5'd2;
    localparam t_cls CLS_AND   = 5'd3;
    localparam t_cls CLS_XOR   = 5'd4;
    localparam t_cls CLS_OR    = 5'd5;
    localparam t_cls CLS_INC   = 5'd6;
    localparam t_cls CLS_DEC   = 5'd7;
    localparam t_cls CLS_ROTA  = 5'd8;
    localparam t_cls CLS_ROTCB = 5'd9;
    localparam t_cls CLS_DAA   = 5'd10;
    localparam t_cls CLS_CPL   = 5'd11;
    localparam t_cls CLS_SCF   = 5'd12;
    localparam t_cls CLS_CCF   = 5'd13;
    localparam t_cls CLS_BIT   = 5'd14;
    localparam t_cls CLS_RES   = 5'd15;
    localparam t_cls CLS_SET   = 5'd16;
    localparam t_cls CLS_UNSUP = 5'd17;

    // Rotate and shift kinds, taken from opcode bits 5:3.
    localparam logic [2:0] RS_RLC  = 3'd0;
    localparam logic [2:0] RS_RRC  = 3'd1;
    localparam logic [2:0] RS_RL   = 3'd2;
    localparam logic [2:0] RS_RR   = 3'd3;
    localparam logic [2:0] RS_SLA  = 3'd4;
    localparam logic [2:0] RS_SRA  = 3'd5;
    localparam logic [2:0] RS_SWAP = 3'd6;
    localparam logic [2:0] RS_SRL  = 3'd7;

    // Flag bit positions.
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Decoded request, held in the first pipeline register.
    typedef struct packed {
        t_cls       cls;
        logic [2:0] row;
        logic [7:0] a;
        logic [7:0] v;
        logic [3:0] f;
        logic       cy;
    } t_dec;

    // Computed request before the zero flag is settled.
    typedef struct packed {
        logic [7:0] res;
        logic       z_from_res;
        logic       z_fix;
        logic       n;
        logic       h;
        logic       c;
        logic       wr;
        logic       sup;
    } t_exe;

    // Returns {carry out, result byte}.
    function automatic logic [8:0] rot_shift(input logic [2:0] kind, input logic [7:0] v,
                                             input logic cin);
        logic [8:0] r;
        begin
            case (kind)
                RS_RLC:  r = {v[7], v[6:0], v[7]};
                RS_RRC:  r = {v[0], v[0], v[7:1]};
                RS_RL:   r = {v[7], v[6:0], cin};
                RS_RR:   r = {v[0], cin, v[7:1]};
                RS_SLA:  r = {v[7], v[6:0], 1'b0};
                RS_SRA:  r = {v[0], v[7], v[7:1]};
                RS_SWAP: r = {1'b0, v[3:0], v[7:4]};
                RS_SRL:  r = {v[0], 1'b0, v[7:1]};
                default: r = {1'b0, v};
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/eight_bit_alu_with_flags.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_opcode i_cb_prefix i_acc i_operand i_flags_in
// result    out        o_valid / i_stall    o_result o_flags_out o_writes_result o_supported
//
// Three register stages: decode, execute, flag/output.
// One request is accepted every cycle while the result side is not stalled.
// The stall ripples back only through full stages, so bubbles are squeezed out.
// Synchronous active-low reset clears the stage valid bits; data registers are not reset.

module eight_bit_alu_with_flags
    import alu8f_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_opcode,
    input  logic       i_cb_prefix,
    input  logic [7:0] i_acc,
    input  logic [7:0] i_operand,
    input  logic [3:0] i_flags_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_result,
    output logic [3:0] o_flags_out,
    output logic       o_writes_result,
    output logic       o_supported
);

    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;
    t_dec n_dec, r_dec;
    t_exe n_exe, r_exe;
    logic [7:0] r_result;
    logic [3:0] r_flags;
    logic       r_wr, r_sup;

    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    // ---------------- decode ----------------
    always_comb begin
        n_dec.row = i_opcode[5:3];
        n_dec.a   = i_acc;
        n_dec.v   = i_operand;
        n_dec.f   = i_flags_in;
        n_dec.cy  = i_opcode[3] & i_flags_in[FLAG_C];
        n_dec.cls = CLS_UNSUP;
        if (i_cb_prefix) begin
            case (i_opcode[7:6])
                2'd0:    n_dec.cls = CLS_ROTCB;
                2'd1:    n_dec.cls = CLS_BIT;
                2'd2:    n_dec.cls = CLS_RES;
                default: n_dec.cls = CLS_SET;
            endcase
        end else if (i_opcode[7:6] == 2'd2) begin
            case (i_opcode[5:4])
                2'd0:    n_dec.cls = CLS_ADD;
                2'd1:    n_dec.cls = CLS_SUB;
                2'd2:    n_dec.cls = i_opcode[3] ? CLS_XOR : CLS_AND;
                default: n_dec.cls = i_opcode[3] ? CLS_CMP : CLS_OR;
            endcase
            // Compare never takes the carry in.
            if (i_opcode[5:3] == 3'd7) begin
                n_dec.cy = 1'b0;
            end
        end else if (i_opcode[7:6] == 2'd0) begin
            case (i_opcode[2:0])
                3'd4: n_dec.cls = CLS_INC;
                3'd5: n_dec.cls = CLS_DEC;
                3'd7: begin
                    case (i_opcode[5:3])
                        3'd4:    n_dec.cls = CLS_DAA;
                        3'd5:    n_dec.cls = CLS_CPL;
                        3'd6:    n_dec.cls = CLS_SCF;
                        3'd7:    n_dec.cls = CLS_CCF;
                        default: n_dec.cls = CLS_ROTA;
                    endcase
                end
                default: n_dec.cls = CLS_UNSUP;
            endcase
        end
    end

    // ---------------- execute ----------------
    logic [8:0] add9, sub9, rot9;
    logic [4:0] add5, sub5;
    logic [7:0] inc8, dec8, mask, daa_adj, daa_res;
    logic       daa_hi, daa_lo, daa_c;

    always_comb begin
        add9 = {1'b0, r_dec.a} + {1'b0, r_dec.v} + {8'd0, r_dec.cy};
        add5 = {1'b0, r_dec.a[3:0]} + {1'b0, r_dec.v[3:0]} + {4'd0, r_dec.cy};
        sub9 = {1'b0, r_dec.a} - {1'b0, r_dec.v} - {8'd0, r_dec.cy};
        sub5 = {1'b0, r_dec.a[3:0]} - {1'b0, r_dec.v[3:0]} - {4'd0, r_dec.cy};
        inc8 = r_dec.v + 8'd1;
        dec8 = r_dec.v - 8'd1;
        mask = 8'd1 << r_dec.row;
        rot9 = rot_shift(r_dec.row,
                         (r_dec.cls == CLS_ROTA) ? r_dec.a : r_dec.v,
                         r_dec.f[FLAG_C]);

        // Decimal adjust: the high correction is decided on the original value,
        // and adding 0x60 leaves the low nibble alone, so one add or subtract does it.
        if (!r_dec.f[FLAG_N]) begin
            daa_hi = r_dec.f[FLAG_C] || (r_dec.a > 8'h99);
            daa_lo = r_dec.f[FLAG_H] || (r_dec.a[3:0] > 4'h9);
        end else begin
            daa_hi = r_dec.f[FLAG_C];
            daa_lo = r_dec.f[FLAG_H];
        end
        daa_adj = (daa_hi ? 8'h60 : 8'h00) | (daa_lo ? 8'h06 : 8'h00);
        daa_res = r_dec.f[FLAG_N] ? (r_dec.a - daa_adj) : (r_dec.a + daa_adj);
        daa_c   = daa_hi;

        n_exe.res        = r_dec.a;
        n_exe.z_from_res = 1'b1;
        n_exe.z_fix      = r_dec.f[FLAG_Z];
        n_exe.n          = 1'b0;
        n_exe.h          = 1'b0;
        n_exe.c          = r_dec.f[FLAG_C];
        n_exe.wr         = 1'b1;
        n_exe.sup        = 1'b1;

        case (r_dec.cls)
            CLS_ADD: begin
                n_exe.res = add9[7:0];
                n_exe.h   = add5[4];
                n_exe.c   = add9[8];
            end
            CLS_SUB: begin
                n_exe.res = sub9[7:0];
                n_exe.n   = 1'b1;
                n_exe.h   = sub5[4];
                n_exe.c   = sub9[8];
            end
            CLS_CMP: begin
                n_exe.z_from_res = 1'b0;
                n_exe.z_fix      = (sub9[7:0] == 8'd0);
                n_exe.n          = 1'b1;
                n_exe.h          = sub5[4];
                n_exe.c          = sub9[8];
                n_exe.wr         = 1'b0;
            end
            CLS_AND: begin
                n_exe.res = r_dec.a & r_dec.v;
                n_exe.h   = 1'b1;
                n_exe.c   = 1'b0;
            end
            CLS_XOR: begin
                n_exe.res = r_dec.a ^ r_dec.v;
                n_exe.c   = 1'b0;
            end
            CLS_OR: begin
                n_exe.res = r_dec.a | r_dec.v;
                n_exe.c   = 1'b0;
            end
            CLS_INC: begin
                n_exe.res = inc8;
                n_exe.h   = (inc8[3:0] == 4'h0);
            end
            CLS_DEC: begin
                n_exe.res = dec8;
                n_exe.n   = 1'b1;
                n_exe.h   = (dec8[3:0] == 4'hF);
            end
            CLS_ROTA: begin
                n_exe.res        = rot9[7:0];
                n_exe.z_from_res = 1'b0;
                n_exe.z_fix      = 1'b0;
                n_exe.c          = rot9[8];
            end
            CLS_ROTCB: begin
                n_exe.res = rot9[7:0];
                n_exe.c   = rot9[8];
            end
            CLS_DAA: begin
                n_exe.res = daa_res;
                n_exe.n   = r_dec.f[FLAG_N];
                n_exe.c   = daa_c;
            end
            CLS_CPL: begin
                n_exe.res        = ~r_dec.a;
                n_exe.z_from_res = 1'b0;
                n_exe.n          = 1'b1;
                n_exe.h          = 1'b1;
            end
            CLS_SCF: begin
                n_exe.z_from_res = 1'b0;
                n_exe.c          = 1'b1;
                n_exe.wr         = 1'b0;
            end
            CLS_CCF: begin
                n_exe.z_from_res = 1'b0;
                n_exe.c          = ~r_dec.f[FLAG_C];
                n_exe.wr         = 1'b0;
            end
            CLS_BIT: begin
                n_exe.res        = r_dec.v;
                n_exe.z_from_res = 1'b0;
                n_exe.z_fix      = ((r_dec.v & mask) == 8'd0);
                n_exe.h          = 1'b1;
                n_exe.wr         = 1'b0;
            end
            CLS_RES, CLS_SET: begin
                n_exe.res        = (r_dec.cls == CLS_SET) ? (r_dec.v | mask)
                                                          : (r_dec.v & ~mask);
                n_exe.z_from_res = 1'b0;
                n_exe.n          = r_dec.f[FLAG_N];
                n_exe.h          = r_dec.f[FLAG_H];
            end
            default: begin
                // Not an ALU opcode: flags pass through, nothing is written.
                n_exe.res        = 8'd0;
                n_exe.z_from_res = 1'b0;
                n_exe.n          = r_dec.f[FLAG_N];
                n_exe.h          = r_dec.f[FLAG_H];
                n_exe.wr         = 1'b0;
                n_exe.sup        = 1'b0;
            end
        endcase
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_dec <= n_dec;
        end
        if (en2) begin
            r_exe <= n_exe;
        end
        if (en3) begin
            r_result <= r_exe.res;
            r_flags  <= {r_exe.z_from_res ? (r_exe.res == 8'd0) : r_exe.z_fix,
                         r_exe.n, r_exe.h, r_exe.c};
            r_wr     <= r_exe.wr;
            r_sup    <= r_exe.sup;
        end
    end

    assign o_valid         = r_v3;
    assign o_result        = r_result;
    assign o_flags_out     = r_flags;
    assign o_writes_result = r_wr;
    assign o_supported     = r_sup;

`ifndef SYNTHESIS
    // An unsupported opcode never reports a written byte.
    a_unsup_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_supported) |-> (!o_writes_result && o_result == 8'd0))
        else $error("unsupported opcode produced a write or nonzero result");

    // Back-pressure reaches the input only when every stage holds a request.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled while a pipeline stage was empty");

    // A decoded request that is not held moves into the execute stage.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !o_stall) |=> r_v2)
        else $error("request lost between decode and execute");

    // A result held by the consumer keeps its valid bit.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_stall) |=> r_v3)
        else $error("stalled result dropped");
`endif

endmodule
